// ===== rtl/fwtl_pkg.sv =====
// ---------------------------------------------------------------------------
// fwtl_pkg: shared types and constants
// Widths, register indexes, reset values and sequencer states for the
// fixed-window token limiter.
// ---------------------------------------------------------------------------
`default_nettype none

package fwtl_pkg;

    localparam int TIME_W     = 48;
    localparam int CNT_W      = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int PROD_W     = TIME_W + CNT_W;
    localparam int STEP_W     = $clog2(PROD_W);
    localparam int MUL_STEPS  = CNT_W;

    localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

    localparam logic [CFG_ADDR_W-1:0] CFG_DURATION = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX      = CFG_ADDR_W'(1);

    localparam logic [CNT_W-1:0] DURATION_RESET = CNT_W'(60000);
    localparam logic [CNT_W-1:0] MAX_RESET      = CNT_W'(1000);

    localparam logic REQ_CHECK  = 1'b0;
    localparam logic REQ_SETTLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DEBT_SETUP,
        ST_DEBT_WAIT,
        ST_FINAL
    } fwtl_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_DIV,
        DV_FIN
    } fwtl_div_phase_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_window_token_limiter_unit.sv =====
// ---------------------------------------------------------------------------
// fixed_window_token_limiter_unit: fixed-window token limiter
// Check requests open windows and admit while usage is below the limit;
// settle requests add usage and push the recover time out for any debt.
// ---------------------------------------------------------------------------
//  channel   signals                                       handshake
//  request   req_type now_ms ticket_start token_count     start / busy
//  result    granted used_now recover_time ticket_window  done (1 cycle)
//  config    cfg_addr cfg_wdata                            cfg_we
//
//  Check and rejected settle: done is registered in ST_EXEC.
//  Settle without debt: done is registered in ST_DEBT_SETUP, after ST_EXEC.
//  Settle with debt: done is registered in ST_FINAL once the serial debt unit
//  finishes (32 multiply steps plus 80 divide steps).
//  busy is high from the cycle after start through the cycle before done;
//  results cannot stall.
//  Reset loads duration 60000, max 1000 and no open window.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_window_token_limiter_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            req_type,
    input  wire logic [fwtl_pkg::TIME_W-1:0]     now_ms,
    input  wire logic [fwtl_pkg::TIME_W-1:0]     ticket_start,
    input  wire logic signed [fwtl_pkg::CNT_W-1:0] token_count,
    output logic                                 done,
    output logic                                 granted,
    output logic [fwtl_pkg::TIME_W-1:0]          used_now,
    output logic [fwtl_pkg::TIME_W-1:0]          recover_time,
    output logic [fwtl_pkg::TIME_W-1:0]          ticket_window,
    input  wire logic                            cfg_we,
    input  wire logic [fwtl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [fwtl_pkg::CNT_W-1:0]      cfg_wdata
);
    import fwtl_pkg::*;

    function automatic logic [TIME_W-1:0] sat_add(
        input logic [TIME_W-1:0] a,
        input logic [TIME_W-1:0] b
    );
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TMAX : s[TIME_W-1:0];
    endfunction

    fwtl_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   dur_reg, dur_next;
    logic [CNT_W-1:0]   max_reg, max_next;
    logic               open_reg, open_next;
    logic [TIME_W-1:0]  begin_reg, begin_next;
    logic [TIME_W-1:0]  used_reg, used_next;
    logic [TIME_W-1:0]  recover_reg, recover_next;
    logic [TIME_W-1:0]  end_reg, end_next;

    logic               type_reg, type_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [TIME_W-1:0]  ticket_reg, ticket_next;
    logic [CNT_W-1:0]   tok_reg, tok_next;

    logic               done_reg, done_next;
    logic               granted_reg, granted_next;
    logic [TIME_W-1:0]  used_now_reg, used_now_next;
    logic [TIME_W-1:0]  recover_time_reg, recover_time_next;
    logic [TIME_W-1:0]  ticket_window_reg, ticket_window_next;

    logic               div_go;
    logic               div_done;
    logic [TIME_W-1:0]  div_ext;
    logic [TIME_W-1:0]  excess;

    logic               open_new;
    logic [TIME_W-1:0]  chk_begin;
    logic [TIME_W-1:0]  chk_used;
    logic [TIME_W-1:0]  chk_recover;
    logic               chk_grant;
    logic               settle_ok;

    fwtl_debt_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (div_go),
        .excess (excess),
        .dur    (dur_reg),
        .mx     (max_reg),
        .done   (div_done),
        .ext    (div_ext)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            dur_reg           <= DURATION_RESET;
            max_reg           <= MAX_RESET;
            open_reg          <= 1'b0;
            begin_reg         <= '0;
            used_reg          <= '0;
            recover_reg       <= '0;
            end_reg           <= '0;
            type_reg          <= REQ_CHECK;
            now_reg           <= '0;
            ticket_reg        <= '0;
            tok_reg           <= '0;
            done_reg          <= 1'b0;
            granted_reg       <= 1'b0;
            used_now_reg      <= '0;
            recover_time_reg  <= '0;
            ticket_window_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            dur_reg           <= dur_next;
            max_reg           <= max_next;
            open_reg          <= open_next;
            begin_reg         <= begin_next;
            used_reg          <= used_next;
            recover_reg       <= recover_next;
            end_reg           <= end_next;
            type_reg          <= type_next;
            now_reg           <= now_next;
            ticket_reg        <= ticket_next;
            tok_reg           <= tok_next;
            done_reg          <= done_next;
            granted_reg       <= granted_next;
            used_now_reg      <= used_now_next;
            recover_time_reg  <= recover_time_next;
            ticket_window_reg <= ticket_window_next;
        end
    end

    // check path: window roll-over then admission
    assign open_new    = !open_reg || (now_reg >= recover_reg);
    assign chk_begin   = open_new ? now_reg : begin_reg;
    assign chk_used    = open_new ? '0 : used_reg;
    assign chk_recover = open_new ? sat_add(now_reg, {{(TIME_W-CNT_W){1'b0}}, dur_reg})
                                  : recover_reg;
    assign chk_grant   = (chk_used < {{(TIME_W-CNT_W){1'b0}}, max_reg});

    assign settle_ok = !tok_reg[CNT_W-1] && open_reg && (ticket_reg == begin_reg);
    assign excess    = used_reg - {{(TIME_W-CNT_W){1'b0}}, max_reg};

    always_comb
    begin
        state_next         = state_reg;
        dur_next           = dur_reg;
        max_next           = max_reg;
        open_next          = open_reg;
        begin_next         = begin_reg;
        used_next          = used_reg;
        recover_next       = recover_reg;
        end_next           = end_reg;
        type_next          = type_reg;
        now_next           = now_reg;
        ticket_next        = ticket_reg;
        tok_next           = tok_reg;
        done_next          = 1'b0;
        granted_next       = granted_reg;
        used_now_next      = used_now_reg;
        recover_time_next  = recover_time_reg;
        ticket_window_next = ticket_window_reg;
        div_go             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    type_next   = req_type;
                    now_next    = now_ms;
                    ticket_next = ticket_start;
                    tok_next    = token_count;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (type_reg == REQ_CHECK)
                begin
                    open_next          = 1'b1;
                    begin_next         = chk_begin;
                    used_next          = chk_used;
                    recover_next       = chk_recover;
                    done_next          = 1'b1;
                    granted_next       = chk_grant;
                    used_now_next      = chk_used;
                    recover_time_next  = chk_recover;
                    ticket_window_next = chk_grant ? chk_begin : '0;
                    state_next         = ST_IDLE;
                end
                else if (settle_ok)
                begin
                    used_next  = sat_add(used_reg,
                                         {{(TIME_W-CNT_W+1){1'b0}}, tok_reg[CNT_W-2:0]});
                    end_next   = sat_add(begin_reg, {{(TIME_W-CNT_W){1'b0}}, dur_reg});
                    state_next = ST_DEBT_SETUP;
                end
                else
                begin
                    done_next          = 1'b1;
                    granted_next       = 1'b0;
                    used_now_next      = used_reg;
                    recover_time_next  = recover_reg;
                    ticket_window_next = '0;
                    state_next         = ST_IDLE;
                end
            end
            ST_DEBT_SETUP:
            begin
                if ((max_reg == '0)
                    || (used_reg <= {{(TIME_W-CNT_W){1'b0}}, max_reg}))
                begin
                    recover_next       = end_reg;
                    done_next          = 1'b1;
                    granted_next       = 1'b1;
                    used_now_next      = used_reg;
                    recover_time_next  = end_reg;
                    ticket_window_next = '0;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    div_go     = 1'b1;
                    state_next = ST_DEBT_WAIT;
                end
            end
            ST_DEBT_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                recover_next       = sat_add(end_reg, div_ext);
                done_next          = 1'b1;
                granted_next       = 1'b1;
                used_now_next      = used_reg;
                recover_time_next  = sat_add(end_reg, div_ext);
                ticket_window_next = '0;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // user keeps register writes to idle, unenforced; accepted writes clear window
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DURATION:
                begin
                    if (cfg_wdata != '0)
                    begin
                        dur_next     = cfg_wdata;
                        open_next    = 1'b0;
                        begin_next   = '0;
                        used_next    = '0;
                        recover_next = '0;
                    end
                end
                CFG_MAX:
                begin
                    max_next     = cfg_wdata;
                    open_next    = 1'b0;
                    begin_next   = '0;
                    used_next    = '0;
                    recover_next = '0;
                end
                default:
                begin
                    max_next = max_reg;
                end
            endcase
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign granted       = granted_reg;
    assign used_now      = used_now_reg;
    assign recover_time  = recover_time_reg;
    assign ticket_window = ticket_window_reg;

endmodule

`default_nettype wire

// ===== rtl/fwtl_debt_div.sv =====
// ---------------------------------------------------------------------------
// fwtl_debt_div: serial debt extension unit
// Computes min(ceil(excess * dur / mx), TMAX) with a shift-add multiply
// (one step per multiplier bit) followed by a restoring radix-2 divide
// (one quotient bit per cycle). mx must be nonzero.
// ---------------------------------------------------------------------------
`default_nettype none

module fwtl_debt_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic [fwtl_pkg::TIME_W-1:0] excess,
    input  wire logic [fwtl_pkg::CNT_W-1:0]  dur,
    input  wire logic [fwtl_pkg::CNT_W-1:0]  mx,
    output logic                             done,
    output logic [fwtl_pkg::TIME_W-1:0]      ext
);
    import fwtl_pkg::*;

    fwtl_div_phase_t     phase_reg, phase_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [TIME_W-1:0]   mcand_reg, mcand_next;
    logic [CNT_W-1:0]    mplier_reg, mplier_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_W-1:0]   ext_reg, ext_next;
    logic                done_reg, done_next;

    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                qbit;
    logic                round_up;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= DV_IDLE;
            acc_reg    <= '0;
            rem_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            cnt_reg    <= '0;
            ext_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            mcand_reg  <= mcand_next;
            mplier_reg <= mplier_next;
            cnt_reg    <= cnt_next;
            ext_reg    <= ext_next;
            done_reg   <= done_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        ext_next    = ext_reg;
        done_next   = 1'b0;
        trial       = {rem_reg, acc_reg[PROD_W-1]};
        diff        = trial - {1'b0, mx};
        qbit        = (trial >= {1'b0, mx});
        round_up    = (rem_reg != '0);

        case (phase_reg)
            DV_IDLE:
            begin
                if (go)
                begin
                    acc_next    = '0;
                    mcand_next  = excess;
                    mplier_next = dur;
                    cnt_next    = '0;
                    phase_next  = DV_MUL;
                end
            end
            DV_MUL:
            begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (mplier_reg[CNT_W-1] ? {{CNT_W{1'b0}}, mcand_reg}
                                                : {PROD_W{1'b0}});
                mplier_next = {mplier_reg[CNT_W-2:0], 1'b0};
                if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    phase_next = DV_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DV_DIV:
            begin
                rem_next = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                acc_next = {acc_reg[PROD_W-2:0], qbit};
                if (cnt_reg == STEP_W'(PROD_W - 1))
                begin
                    cnt_next   = '0;
                    phase_next = DV_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DV_FIN:
            begin
                if ((acc_reg[PROD_W-1:TIME_W] != '0)
                    || ((acc_reg[TIME_W-1:0] == TMAX) && round_up))
                begin
                    ext_next = TMAX;
                end
                else
                begin
                    ext_next = acc_reg[TIME_W-1:0] + TIME_W'(round_up);
                end
                done_next  = 1'b1;
                phase_next = DV_IDLE;
            end
            default:
            begin
                phase_next = DV_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign ext  = ext_reg;

endmodule

`default_nettype wire

// ===== tb/sv/fwtl_checker.sv =====
// ---------------------------------------------------------------------------
// fwtl_checker: result checker for the fixed-window token limiter
// Watches the request, result and config ports, keeps its own copy of the
// window state, predicts every result and compares it field by field.
// ---------------------------------------------------------------------------
module fwtl_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              req_type,
    input  logic [fwtl_pkg::TIME_W-1:0]       now_ms,
    input  logic [fwtl_pkg::TIME_W-1:0]       ticket_start,
    input  logic signed [fwtl_pkg::CNT_W-1:0] token_count,
    input  logic                              done,
    input  logic                              granted,
    input  logic [fwtl_pkg::TIME_W-1:0]       used_now,
    input  logic [fwtl_pkg::TIME_W-1:0]       recover_time,
    input  logic [fwtl_pkg::TIME_W-1:0]       ticket_window,
    input  logic                              cfg_we,
    input  logic [fwtl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [fwtl_pkg::CNT_W-1:0]        cfg_wdata,
    output int                                mismatches,
    output int                                pending,
    output int                                n_requests,
    output int                                n_grants,
    output int                                n_debts
);
    timeunit 1ns;
    timeprecision 1ps;
    import fwtl_pkg::*;

    typedef struct {
        logic              ok;
        logic [TIME_W-1:0] used;
        logic [TIME_W-1:0] reopen;
        logic [TIME_W-1:0] ticket;
    } limiter_result_t;

    limiter_result_t   expected_results[$];

    logic [CNT_W-1:0]  win_len;
    logic [CNT_W-1:0]  token_cap;
    logic              win_live;
    logic [TIME_W-1:0] win_start;
    logic [TIME_W-1:0] tok_used;
    logic [TIME_W-1:0] reopen_at;

    initial
    begin
        mismatches = 0;
        pending    = 0;
        n_requests = 0;
        n_grants   = 0;
        n_debts    = 0;
    end

    function automatic logic [TIME_W-1:0] clamp_add(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TMAX : s[TIME_W-1:0];
    endfunction

    // ceil(excess * len / cap) done in full width, then clamped
    function automatic logic [TIME_W-1:0] debt_delay(input logic [TIME_W-1:0] excess);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quo;
        prod = PROD_W'(excess) * PROD_W'(win_len);
        quo  = prod / PROD_W'(token_cap);
        if (prod % PROD_W'(token_cap) != '0)
            quo = quo + 1'b1;
        return (quo > PROD_W'(TMAX)) ? TMAX : quo[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] reopen_time();
        logic [TIME_W-1:0] win_end;
        win_end = clamp_add(win_start, TIME_W'(win_len));
        if (token_cap == '0 || tok_used <= TIME_W'(token_cap))
            return win_end;
        return clamp_add(win_end, debt_delay(tok_used - TIME_W'(token_cap)));
    endfunction

    task automatic clear_window();
        win_live  = 1'b0;
        win_start = '0;
        tok_used  = '0;
        reopen_at = '0;
    endtask

    task automatic predict_request();
        limiter_result_t r;
        r.ok     = 1'b0;
        r.ticket = '0;
        if (req_type == REQ_CHECK)
        begin
            if (!win_live || now_ms >= reopen_at)
            begin
                win_live  = 1'b1;
                win_start = now_ms;
                tok_used  = '0;
                reopen_at = clamp_add(now_ms, TIME_W'(win_len));
            end
            if (tok_used < TIME_W'(token_cap))
            begin
                r.ok     = 1'b1;
                r.ticket = win_start;
            end
        end
        else if (!token_count[CNT_W-1] && win_live && ticket_start == win_start)
        begin
            tok_used  = clamp_add(tok_used, {{(TIME_W-CNT_W){1'b0}}, token_count});
            reopen_at = reopen_time();
            r.ok      = 1'b1;
            if (token_cap != '0 && tok_used > TIME_W'(token_cap))
                n_debts++;
        end
        r.used   = tok_used;
        r.reopen = reopen_at;
        if (r.ok)
            n_grants++;
        n_requests++;
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        limiter_result_t want;
        if (!rst_n)
        begin
            win_len   = DURATION_RESET;
            token_cap = MAX_RESET;
            clear_window();
            expected_results.delete();
        end
        else
        begin
            // compare first: a result and a new request can share an edge
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display({"%0t: unexpected result: expected none, ",
                              "got granted=%0b used=%h recover=%h ticket=%h"},
                             $time, granted, used_now, recover_time, ticket_window);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("granted", TIME_W'(want.ok), TIME_W'(granted));
                    check_field("used_now", want.used, used_now);
                    check_field("recover_time", want.reopen, recover_time);
                    check_field("ticket_window", want.ticket, ticket_window);
                end
            end
            if (cfg_we)
            begin
                if (cfg_addr == CFG_DURATION)
                begin
                    // zero duration is dropped, state kept
                    if (cfg_wdata != '0)
                    begin
                        win_len = cfg_wdata;
                        clear_window();
                    end
                end
                else if (cfg_addr == CFG_MAX)
                begin
                    token_cap = cfg_wdata;
                    clear_window();
                end
            end
            if (start && !busy)
                predict_request();
        end
        pending = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench for the fixed-window token limiter
// Directed requests cover window opening, debt carry-over, saturation,
// rejected settles and the register special cases; random check/settle
// traffic then runs under several limit settings and sender idle rates.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fwtl_pkg::*;

    localparam int LIMIT_NS = 5_000_000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    req_type = REQ_CHECK;
    logic [TIME_W-1:0]       now_ms = '0;
    logic [TIME_W-1:0]       ticket_start = '0;
    logic signed [CNT_W-1:0] token_count = '0;
    logic                    done;
    logic                    granted;
    logic [TIME_W-1:0]       used_now;
    logic [TIME_W-1:0]       recover_time;
    logic [TIME_W-1:0]       ticket_window;
    logic                    cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [CNT_W-1:0]        cfg_wdata = '0;

    int mismatches;
    int pending;
    int n_requests;
    int n_grants;
    int n_debts;

    logic [CNT_W-1:0]  cur_len = DURATION_RESET;
    logic [CNT_W-1:0]  cur_cap = MAX_RESET;
    logic [TIME_W-1:0] clock_ms = '0;
    logic [TIME_W-1:0] last_ticket = '0;
    int unsigned       idle_pct = 0;

    fixed_window_token_limiter_unit uut (.*);

    fwtl_checker chk (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // most recent window start handed out, for well-formed settles
    always @(posedge clk)
        if (done && ticket_window != '0)
            last_ticket <= ticket_window;

    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] next_now();
        case ($urandom_range(19))
            0:       clock_ms = rand48();
            1:       clock_ms = TMAX - TIME_W'($urandom_range(cur_len));
            2, 3:    clock_ms = clock_ms + TIME_W'(cur_len) + TIME_W'($urandom_range(3));
            4:       clock_ms = clock_ms + TIME_W'(cur_len) * TIME_W'($urandom_range(2, 40));
            default: clock_ms = clock_ms + TIME_W'($urandom_range(cur_len / 8 + 1));
        endcase
        return clock_ms;
    endfunction

    function automatic logic [CNT_W-1:0] pick_tokens();
        logic [CNT_W-1:0] span;
        span = (cur_cap > 32'd100000) ? 32'd200000 : cur_cap * 2 + 3;
        case ($urandom_range(9))
            0:       return {1'b1, 31'($urandom)};
            1:       return {1'b0, 31'($urandom)};
            2:       return '0;
            default: return $urandom_range(span);
        endcase
    endfunction

    task automatic idle_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic issue(input logic kind, input logic [TIME_W-1:0] now,
                         input logic [TIME_W-1:0] tick, input logic [CNT_W-1:0] tok);
        idle_gap();
        start        <= 1'b1;
        req_type     <= kind;
        now_ms       <= now;
        ticket_start <= tick;
        token_count  <= tok;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic send_check(input logic [TIME_W-1:0] now);
        issue(REQ_CHECK, now, rand48(), $urandom);
    endtask

    task automatic send_settle(input logic [TIME_W-1:0] tick, input logic [CNT_W-1:0] tok);
        issue(REQ_SETTLE, rand48(), tick, tok);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CNT_W-1:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_DURATION && data != '0)
            cur_len = data;
        else if (addr == CFG_MAX)
            cur_cap = data;
    endtask

    task automatic random_request();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            send_check(next_now());
        else if (pick < 90)
            send_settle(last_ticket, pick_tokens());
        else if (pick < 95)
            send_settle(rand48(), $urandom);
        else
            send_settle(last_ticket ^ (48'd1 << $urandom_range(TIME_W - 1)), pick_tokens());
    endtask

    initial
    begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limits: 60000 ms, 1000 tokens
        send_settle(48'd0, 32'd5);                  // no window yet
        send_check(48'd0);
        send_settle(48'd0, 32'd999);
        send_check(48'd100);
        send_settle(48'd0, 32'd1);                  // exactly at the cap
        send_check(48'd200);                        // denied
        send_settle(48'd0, 32'hFFFF_FFFF);          // negative
        send_settle(48'd5, 32'd10);                 // stale ticket
        send_settle(48'd0, 32'd500);                // debt
        send_check(48'd60000);                      // still in debt
        send_check(48'd90000);
        send_settle(48'd90000, 32'h7FFF_FFFF);
        send_check(TMAX);
        send_settle(TMAX, 32'd2000);                // recover clamps

        write_reg(CFG_MAX, 32'd1);
        write_reg(CFG_DURATION, 32'hFFFF_FFFF);
        send_check(48'h8000_0000_0000);
        send_settle(48'h8000_0000_0000, 32'h7FFF_FFFF);
        write_reg(CFG_DURATION, 32'd0);             // dropped
        send_check(48'h8000_0000_0001);

        write_reg(CFG_MAX, 32'd0);
        send_check(48'd10);
        send_settle(48'd10, 32'd100);
        send_settle(48'd10, 32'd0);

        write_reg(CFG_DURATION, 32'd1);
        write_reg(CFG_MAX, 32'd2);
        send_check(48'd5);
        send_settle(48'd5, 32'd3);                  // one token of debt
        send_check(48'd6);
        send_check(48'd7);

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = (ph < 2) ? 6 : (ph < 4) ? 80 : 0;
            case (ph)
                0:
                begin
                    write_reg(CFG_DURATION, 32'd1000);
                    write_reg(CFG_MAX, 32'd100);
                end
                1:
                begin
                    write_reg(CFG_DURATION, 32'hFFFF_FFFF);
                    write_reg(CFG_MAX, 32'd1);
                end
                2:
                begin
                    write_reg(CFG_DURATION, 32'd1);
                    write_reg(CFG_MAX, 32'hFFFF_FFFF);
                end
                3:
                begin
                    write_reg(CFG_DURATION, $urandom_range(1, 100000));
                    write_reg(CFG_MAX, $urandom_range(0, 50));
                end
                4:
                begin
                    write_reg(CFG_MAX, 32'd0);
                    write_reg(CFG_DURATION, 32'd0);
                    write_reg(CFG_DURATION, 32'd5000);
                end
                default:
                begin
                    write_reg(CFG_DURATION, $urandom | 32'd1);
                    write_reg(CFG_MAX, $urandom_range(1, 2000));
                end
            endcase
            clock_ms = rand48() >> $urandom_range(TIME_W - 1);
            for (int n = 0; n < 85; n++)
                random_request();
        end

        drain();
        repeat (4) @(negedge clk);
        $display("summary: %0d requests checked, %0d granted, %0d with debt carry-over",
                 n_requests, n_grants, n_debts);
        $display("summary: 6 limit settings plus edge cases, sender idle 6%%, 80%% and none");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fwtl_pkg.sv
rtl/fwtl_debt_div.sv
rtl/fixed_window_token_limiter_unit.sv
tb/sv/fwtl_checker.sv
tb/sv/tb_top.sv
